// File: design/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int CDQ_DEPTH   = 16;
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int LIM_W       = 5;

    localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_REAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK      = 3'd4;

    // at most one bit set; broadcast to every cell
    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic push_rear;
        logic pop_rear;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: design/circular_deque.sv
`default_nettype none

// circular_deque: double-ended queue of signed 32-bit words.
// Command channel: start with i_func/i_value is taken at a clock edge where
// busy is low; busy is never raised, so one command may be given every
// cycle. Functions: insert front, insert rear, delete front, delete rear,
// peek; codes 5 to 7 change nothing and report ok low.
// Result: exactly one word per command, shown for one cycle on the o_ ports
// with o_done high, in the cycle after the command is taken. The receiver
// cannot stall, so nothing is held back; throughput is one command a cycle.
// Storage is a row of DEPTH cells with cell 0 at the front: front inserts
// and deletes shift the whole row by one place, rear inserts and deletes
// touch only one cell at the rear end of the occupied run. The rear word is
// picked by an and-or over the cells flagged as last.
// Configuration: i_cfg_we writes the entry limit (clamped to 1..DEPTH);
// write it only while no command is in flight.
// Reset (synchronous, active low) empties the deque and sets the limit
// to 16; the stored words themselves are not cleared.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic signed [WORD_W-1:0] i_value,
    input  wire logic                     i_cfg_we,
    input  wire logic [LIM_W-1:0]         i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_ok,
    output logic signed [WORD_W-1:0]      o_front_value,
    output logic signed [WORD_W-1:0]      o_rear_value,
    output logic                          o_is_empty,
    output logic                          o_is_full
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LIM_W) ? CW : LIM_W;

    logic [CW-1:0]    r_count, n_count;
    logic [LIM_W-1:0] r_lim;
    logic             r_done, r_ok, n_ok;
    logic [CMPW-1:0]  lim_eff;
    logic             full, empty, accept;
    t_cell_ctl        ctl;

    logic [WORD_W-1:0] cell_data  [DEPTH];
    logic              cell_valid [DEPTH];
    logic              cell_last  [DEPTH];
    logic [DEPTH-1:0]  valid_vec;
    logic [WORD_W-1:0] rear_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        if (r_lim == '0) begin
            lim_eff = CMPW'(1);
        end else if (CMPW'(r_lim) > CMPW'(DEPTH)) begin
            lim_eff = CMPW'(DEPTH);
        end else begin
            lim_eff = CMPW'(r_lim);
        end
    end

    assign full  = CMPW'(r_count) >= lim_eff;
    assign empty = (r_count == '0);

    always_comb begin
        ctl     = '0;
        n_count = r_count;
        n_ok    = 1'b0;
        case (i_func)
            FN_INS_FRONT: begin
                if (!full) begin
                    ctl.shift_r = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_ok        = 1'b1;
                end
            end
            FN_INS_REAR: begin
                if (!full) begin
                    ctl.push_rear = 1'b1;
                    n_count       = r_count + CW'(1);
                    n_ok          = 1'b1;
                end
            end
            FN_DEL_FRONT: begin
                if (!empty) begin
                    ctl.shift_l = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_ok        = 1'b1;
                end
            end
            FN_DEL_REAR: begin
                if (!empty) begin
                    ctl.pop_rear = 1'b1;
                    n_count      = r_count - CW'(1);
                    n_ok         = 1'b1;
                end
            end
            FN_PEEK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (!accept) begin
            ctl     = '0;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lim   <= LIM_RESET;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
            r_ok    <= accept && n_ok;
            if (i_cfg_we) begin
                r_lim <= i_cfg_wdata;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_W-1:0] left_data, right_data;
            logic              left_valid, right_valid;
            if (gi == 0) begin : g_head
                assign left_data  = i_value;
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_data  = cell_data[gi-1];
                assign left_valid = cell_valid[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_data  = cell_data[gi+1];
                assign right_valid = cell_valid[gi+1];
            end
            cdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_word        (i_value),
                .i_left_data   (left_data),
                .i_left_valid  (left_valid),
                .i_right_data  (right_data),
                .i_right_valid (right_valid),
                .o_data        (cell_data[gi]),
                .o_valid       (cell_valid[gi]),
                .o_last        (cell_last[gi])
            );
            assign valid_vec[gi] = cell_valid[gi];
        end
    endgenerate

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | (cell_last[i] ? cell_data[i] : '0);
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_is_empty    = empty;
    assign o_is_full     = full;
    assign o_front_value = empty ? '1 : cell_data[0];
    assign o_rear_value  = empty ? '1 : rear_word;

    // occupied cells form one run from the front; their number must equal the count
    a_run_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("cell occupancy disagrees with entry count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_refused_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_func == FN_INS_FRONT || i_func == FN_INS_REAR))
        |=> (!o_ok && $stable(r_count)))
        else $error("insert taken while full");

    a_refused_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && empty && (i_func == FN_DEL_FRONT || i_func == FN_DEL_REAR))
        |=> (!o_ok && o_is_empty))
        else $error("delete taken while empty");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("command gave no result word");

endmodule

`default_nettype wire

// File: design/cdq_cell.sv
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [WORD_W-1:0] i_left_data,
    input  wire logic              i_left_valid,
    input  wire logic [WORD_W-1:0] i_right_data,
    input  wire logic              i_right_valid,
    output logic      [WORD_W-1:0] o_data,
    output logic                   o_valid,
    output logic                   o_last
);

    logic [WORD_W-1:0] r_data, n_data;
    logic              r_valid, n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.shift_r) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctl.shift_l) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctl.push_rear) begin
            // first free cell after the occupied run takes the word
            if (!r_valid && i_left_valid) begin
                n_data  = i_word;
                n_valid = 1'b1;
            end
        end else if (i_ctl.pop_rear) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;

endmodule

`default_nettype wire
